// ===== hw/rtl/rbcf_pkg.sv =====
// shared types and constants for the relay board command framer
package rbcf_pkg;

  localparam int RELAY_COUNT = 8;
  localparam int REPLY_DEPTH = 64;
  localparam int HDR_BYTES = 2;
  localparam int CNT_W = $clog2(REPLY_DEPTH);
  localparam int RELAY_IDX_W = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W = 4;

  localparam logic [7:0] NODE_ADDR = 8'hFF;
  localparam logic [7:0] OP_READ = 8'hA0;
  localparam logic [7:0] OP_ON = 8'h01;
  localparam logic [7:0] OP_OFF = 8'h00;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_BYTE = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_BOX = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [1:0] REG_BOX_MIN = 2'd0;
  localparam logic [1:0] REG_BOX_MAX = 2'd1;
  localparam logic [1:0] REG_INDEX_LIMIT = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [7:0] box_min;
    logic [7:0] box_max;
    logic [7:0] index_limit;
    logic [7:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic       is_frame;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] status;
    logic [7:0] states;
  } job_t;

endpackage

// ===== hw/rtl/rbcf_queue.sv =====
// small job queue between the command front end and the result sequencer
module rbcf_queue import rbcf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= QCNT_W'(count + 1'b1);
        2'b01:   count <= QCNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rbcf_front.sv =====
// command front end: validation, reply collection state and job building
module rbcf_front import rbcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [1:0] cmd,
  input  logic [7:0] box_id,
  input  logic [7:0] relay_num,
  input  logic       relay_on,
  input  logic [7:0] rx_data,
  output logic       push,
  output job_t       push_job
);

  logic                   read_pending;
  logic [CNT_W-1:0]       byte_count;
  logic [7:0]             elapsed_ticks;
  logic [RELAY_COUNT-1:0] relay_flags;

  logic                   read_pending_next;
  logic [CNT_W-1:0]       byte_count_next;
  logic [7:0]             elapsed_ticks_next;
  logic [RELAY_COUNT-1:0] relay_flags_next;

  logic                   box_bad;
  logic [15:0]            product;
  logic [8:0]             tick_sum;
  logic                   in_relay_window;
  logic                   reply_done;
  logic [RELAY_IDX_W-1:0] relay_pos;

  assign box_bad = (box_id < cfg.box_min) || (box_id > cfg.box_max);
  assign product = 16'(box_id) * 16'(relay_num);
  assign tick_sum = 9'(elapsed_ticks) + 9'd1;
  assign in_relay_window = (byte_count >= CNT_W'(HDR_BYTES)) &&
                           (byte_count < CNT_W'(HDR_BYTES + RELAY_COUNT));
  assign reply_done = (byte_count >= CNT_W'(HDR_BYTES + RELAY_COUNT));
  assign relay_pos = RELAY_IDX_W'(byte_count - CNT_W'(HDR_BYTES));

  always_comb begin
    push = 1'b0;
    push_job = '0;
    read_pending_next = read_pending;
    byte_count_next = byte_count;
    elapsed_ticks_next = elapsed_ticks;
    relay_flags_next = relay_flags;
    unique case (cmd)
      CMD_WRITE: begin
        if (!read_pending) begin
          push = 1'b1;
          if (box_bad) begin
            push_job.status = ST_BAD_BOX;
          end else if (relay_num > cfg.index_limit) begin
            push_job.status = ST_BAD_INDEX;
          end else begin
            push_job.is_frame = 1'b1;
            push_job.b1 = product[7:0];
            push_job.b2 = relay_on ? OP_ON : OP_OFF;
          end
        end
      end
      CMD_READ: begin
        if (!read_pending) begin
          push = 1'b1;
          if (box_bad) begin
            push_job.status = ST_BAD_BOX;
          end else begin
            push_job.is_frame = 1'b1;
            push_job.b1 = OP_READ | box_id;
            push_job.b2 = OP_OFF;
            relay_flags_next = '0;
            byte_count_next = '0;
            elapsed_ticks_next = '0;
            read_pending_next = 1'b1;
          end
        end
      end
      CMD_BYTE: begin
        if (read_pending) begin
          if (in_relay_window) begin
            relay_flags_next[relay_pos] = (rx_data != 8'd0);
          end
          byte_count_next = CNT_W'(byte_count + 1'b1);
        end
      end
      CMD_TICK: begin
        if (read_pending) begin
          elapsed_ticks_next = tick_sum[8] ? 8'hFF : tick_sum[7:0];
          if (reply_done) begin
            push = 1'b1;
            push_job.status = ST_OK;
            push_job.states = 8'(relay_flags);
            read_pending_next = 1'b0;
          end else if (tick_sum > 9'(cfg.timeout)) begin
            push = 1'b1;
            push_job.status = ST_TIMEOUT;
            read_pending_next = 1'b0;
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
    if (!take) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pending <= 1'b0;
      byte_count <= '0;
      elapsed_ticks <= '0;
      relay_flags <= '0;
    end else if (take) begin
      read_pending <= read_pending_next;
      byte_count <= byte_count_next;
      elapsed_ticks <= elapsed_ticks_next;
      relay_flags <= relay_flags_next;
    end
  end

endmodule

// ===== hw/rtl/rbcf_back.sv =====
// result sequencer: expands queued jobs into frame bytes or status results
module rbcf_back import rbcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic [1:0] status,
  output logic [7:0] relay_states,
  output logic       last
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] step;

  logic       load_out;
  logic       cur_last;
  logic       res_tx_valid;
  logic [7:0] res_tx_byte;

  assign load_out = cur_valid && (!out_valid || out_ready);
  assign cur_last = !cur.is_frame || (step == 2'd2);
  assign pop = head_valid && (!cur_valid || (load_out && cur_last));

  always_comb begin
    res_tx_valid = cur.is_frame;
    res_tx_byte = 8'd0;
    if (cur.is_frame) begin
      unique case (step)
        2'd0:    res_tx_byte = NODE_ADDR;
        2'd1:    res_tx_byte = cur.b1;
        default: res_tx_byte = cur.b2;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      step <= '0;
    end else if (load_out) begin
      if (cur_last) begin
        cur_valid <= 1'b0;
      end else begin
        step <= 2'(step + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      tx_valid <= res_tx_valid;
      tx_byte <= res_tx_byte;
      status <= cur.status;
      relay_states <= cur.states;
      last <= cur_last;
    end
  end

endmodule

// ===== hw/rtl/relay_board_command_framer.sv =====
// top level of the relay board command framer with register port
// path: an accepted input is written into the job queue, then loaded into the
// current job register and from there into the output registers
// throughput: one input per cycle while the four-entry job queue is not full; the
// output side gives one result per cycle while out_ready is high; a frame command
// gives three results and an error, answer or timeout one; other inputs give none
// reset: synchronous active-high rst clears control state and loads register defaults
module relay_board_command_framer import rbcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [7:0]         box_id,
  input  logic [7:0]         relay_num,
  input  logic               relay_on,
  input  logic [7:0]         rx_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               tx_valid,
  output logic [7:0]         tx_byte,
  output logic [1:0]         status,
  output logic [7:0]         relay_states,
  output logic               last
);

  cfg_t       cfg;
  logic [1:0] reg_sel;
  logic       cfg_write;
  logic       take;
  logic       push;
  job_t       push_job;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  job_t       head_job;

  assign pready = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_min <= 8'd1;
      cfg.box_max <= 8'd4;
      cfg.index_limit <= 8'd8;
      cfg.timeout <= 8'd20;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_BOX_MIN:     cfg.box_min <= pwdata[7:0];
        REG_BOX_MAX:     cfg.box_max <= pwdata[7:0];
        REG_INDEX_LIMIT: cfg.index_limit <= pwdata[7:0];
        default:         cfg.timeout <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BOX_MIN:     prdata = 32'(cfg.box_min);
      REG_BOX_MAX:     prdata = 32'(cfg.box_max);
      REG_INDEX_LIMIT: prdata = 32'(cfg.index_limit);
      default:         prdata = 32'(cfg.timeout);
    endcase
  end

  assign in_ready = !q_full;
  assign take = in_valid && in_ready;

  rbcf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .cmd         (cmd),
    .box_id      (box_id),
    .relay_num   (relay_num),
    .relay_on    (relay_on),
    .rx_data     (rx_data),
    .push        (push),
    .push_job    (push_job)
  );

  rbcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  rbcf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .status       (status),
    .relay_states (relay_states),
    .last         (last)
  );

  // error and timeout results carry no frame byte and end the transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> !tx_valid && last && (tx_byte == 8'd0))
    else $error("status result carries a frame byte");

  // relay states only appear on a read answer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (relay_states != 8'd0) |-> !tx_valid && (status == ST_OK) && last)
    else $error("relay states outside a read answer");

  // the front end never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into full queue");

endmodule
